// ----- rtl/rerc_pkg.sv -----
// Shared types, codes and constants for the rotary encoder range counter.
package rerc_pkg;

	localparam int RERC_VALUE_WIDTH = 16;
	localparam int RERC_MAX_STEPS   = 16;
	localparam int CMD_WIDTH        = 2;
	localparam int REG_IDX_WIDTH    = 3;
	localparam int ACC_WIDTH        = 8;
	localparam int WRAP_WIDTH       = 4;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = 8'sh80;
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = 8'sh7f;
	localparam logic signed [ACC_WIDTH-1:0] ACC_ONE = 8'sd1;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_SET    = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_RANGE_MIN     = 3'd0,
		REG_RANGE_MAX     = 3'd1,
		REG_STEP_SIZE     = 3'd2,
		REG_WRAP_MODE     = 3'd3,
		REG_HIGH_IS_CLOSE = 3'd4,
		REG_TICK_ENABLE   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic add;
		logic chk;
		logic mod_step;
		logic mod_fin;
		logic load_out;
	} rerc_ctl_t;

	typedef struct packed {
		logic tick_go;
		logic mod_start;
		logic mod_last;
		logic out_free;
	} rerc_sts_t;

endpackage

// ----- rtl/rerc_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
module rerc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rerc_pkg::rerc_sts_t sts,
	output rerc_pkg::rerc_ctl_t ctl
);
	import rerc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_ADD   = 7'b0000100,
		ST_CHK   = 7'b0001000,
		ST_MOD   = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_WRITE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.cap = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = sts.tick_go ? ST_ADD : ST_WRITE;
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				ctl.chk = 1'b1;
				state_d = sts.mod_start ? ST_MOD : ST_WRITE;
			end
			ST_MOD: begin
				ctl.mod_step = 1'b1;
				state_d      = sts.mod_last ? ST_FIN : ST_MOD;
			end
			ST_FIN: begin
				ctl.mod_fin = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ----- rtl/rerc_datapath.sv -----
// Datapath: configuration, decoder state, step arithmetic, range wrap and result register.
module rerc_datapath #(
	parameter int VALUE_WIDTH = rerc_pkg::RERC_VALUE_WIDTH,
	parameter int MAX_STEPS   = rerc_pkg::RERC_MAX_STEPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [rerc_pkg::REG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [VALUE_WIDTH-1:0]                cfg_data,
	input  logic [rerc_pkg::CMD_WIDTH-1:0]        command,
	input  logic                                  clock_contact,
	input  logic                                  direction_contact,
	input  logic signed [VALUE_WIDTH-1:0]         new_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [VALUE_WIDTH-1:0]         current_value,
	output logic                                  pending_change,
	output logic                                  value_moved,
	input  rerc_pkg::rerc_ctl_t                   ctl,
	output rerc_pkg::rerc_sts_t                   sts
);
	import rerc_pkg::*;

	localparam int SW = VALUE_WIDTH + 9;
	localparam int PW = VALUE_WIDTH + ACC_WIDTH;
	localparam int CW = $clog2(SW);
	localparam logic signed [ACC_WIDTH-1:0] MS = ACC_WIDTH'(MAX_STEPS);

	logic signed [VALUE_WIDTH-1:0] range_min_q;
	logic signed [VALUE_WIDTH-1:0] range_max_q;
	logic signed [VALUE_WIDTH-1:0] step_size_q;
	logic [WRAP_WIDTH-1:0]         wrap_mode_q;
	logic                          high_is_close_q;
	logic                          tick_enable_q;

	cmd_t                          cmd_q;
	logic                          clk_in_q;
	logic                          dir_in_q;
	logic signed [VALUE_WIDTH-1:0] new_q;

	logic                          last_closed_q;
	logic                          dir_close_q;
	logic signed [ACC_WIDTH-1:0]   acc_q;
	logic signed [VALUE_WIDTH-1:0] held_q;
	logic                          pending_q;
	logic                          moved_q;

	logic signed [PW-1:0]          prod_q;
	logic signed [SW-1:0]          sum_q;
	logic [SW-1:0]                 dvd_q;
	logic [VALUE_WIDTH-1:0]        rem_q;
	logic [CW-1:0]                 bit_cnt_q;
	logic                          below_q;

	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic                          out_pending_q;
	logic                          out_moved_q;

	logic signed [VALUE_WIDTH-1:0] lo;
	logic signed [VALUE_WIDTH-1:0] hi;
	logic [VALUE_WIDTH:0]          span;
	logic                          clk_lvl;
	logic                          dir_lvl;
	logic                          tick_go;
	logic signed [VALUE_WIDTH-1:0] set_val;
	logic                          over;
	logic                          under;
	logic signed [SW-1:0]          ex_over;
	logic signed [SW-1:0]          ex_under;
	logic [VALUE_WIDTH:0]          trial;
	logic [VALUE_WIDTH-1:0]        rem_d;

	assign lo   = (range_min_q < range_max_q) ? range_min_q : range_max_q;
	assign hi   = (range_min_q < range_max_q) ? range_max_q : range_min_q;
	assign span = {hi[VALUE_WIDTH-1], hi} - {lo[VALUE_WIDTH-1], lo} + (VALUE_WIDTH+1)'(1);

	assign clk_lvl = clk_in_q ^ ~high_is_close_q;
	assign dir_lvl = dir_in_q ^ ~high_is_close_q;

	assign tick_go = (cmd_q == CMD_TICK) && (acc_q != '0) && tick_enable_q
		&& (acc_q < MS) && (acc_q > -MS);

	assign set_val = (new_q < lo) ? lo : ((new_q > hi) ? hi : new_q);

	assign over     = sum_q > SW'(hi);
	assign under    = sum_q < SW'(lo);
	assign ex_over  = sum_q - SW'(hi) - SW'(1);
	assign ex_under = SW'(lo) - sum_q - SW'(1);

	assign trial = {rem_q, dvd_q[SW-1]};
	assign rem_d = (trial >= span) ? VALUE_WIDTH'(trial - span) : trial[VALUE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q     <= VALUE_WIDTH'(10);
			range_max_q     <= VALUE_WIDTH'(20);
			step_size_q     <= VALUE_WIDTH'(1);
			wrap_mode_q     <= '0;
			high_is_close_q <= 1'b1;
			tick_enable_q   <= 1'b1;
		end else if (cfg_write_en) begin
			case (reg_idx_t'(cfg_index))
				REG_RANGE_MIN:     range_min_q     <= cfg_data;
				REG_RANGE_MAX:     range_max_q     <= cfg_data;
				REG_STEP_SIZE:     step_size_q     <= cfg_data;
				REG_WRAP_MODE:     wrap_mode_q     <= cfg_data[WRAP_WIDTH-1:0];
				REG_HIGH_IS_CLOSE: high_is_close_q <= cfg_data[0];
				REG_TICK_ENABLE:   tick_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q    <= cmd_t'(command);
			clk_in_q <= clock_contact;
			dir_in_q <= direction_contact;
			new_q    <= new_value;
		end
		if (ctl.exec) begin
			prod_q <= PW'(acc_q) * PW'(step_size_q);
		end
		if (ctl.add) begin
			sum_q <= SW'(held_q) + SW'(prod_q);
		end
		if (ctl.chk) begin
			below_q   <= !over;
			dvd_q     <= over ? ex_over : ex_under;
			rem_q     <= '0;
			bit_cnt_q <= CW'(SW - 1);
		end
		if (ctl.mod_step) begin
			rem_q     <= rem_d;
			dvd_q     <= dvd_q << 1;
			bit_cnt_q <= bit_cnt_q - CW'(1);
		end
		if (ctl.load_out) begin
			out_value_q   <= held_q;
			out_pending_q <= pending_q;
			out_moved_q   <= moved_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_closed_q <= 1'b0;
			dir_close_q   <= 1'b0;
			acc_q         <= '0;
			held_q        <= VALUE_WIDTH'(10);
			pending_q     <= 1'b0;
			moved_q       <= 1'b0;
		end else begin
			if (ctl.exec) begin
				moved_q <= 1'b0;
				case (cmd_q)
					CMD_SAMPLE: begin
						if (!last_closed_q && clk_lvl) begin
							last_closed_q <= 1'b1;
							dir_close_q   <= dir_lvl;
						end else if (last_closed_q && !clk_lvl) begin
							if (dir_close_q && !dir_lvl) begin
								if (acc_q != ACC_MIN) begin
									acc_q <= acc_q - ACC_ONE;
								end
							end else if (!dir_close_q && dir_lvl) begin
								if (acc_q != ACC_MAX) begin
									acc_q <= acc_q + ACC_ONE;
								end
							end
							last_closed_q <= 1'b0;
							dir_close_q   <= dir_lvl;
						end
					end
					CMD_TICK: begin
						acc_q <= '0;
						if (tick_go) begin
							pending_q <= 1'b1;
							moved_q   <= 1'b1;
						end
					end
					CMD_SET: begin
						held_q    <= set_val;
						pending_q <= 1'b0;
						acc_q     <= '0;
					end
					CMD_READ: begin
						pending_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (ctl.chk) begin
				if (over) begin
					if (!wrap_mode_q[0]) begin
						held_q <= hi;
					end else if (wrap_mode_q[1]) begin
						held_q <= lo;
					end
				end else if (under) begin
					if (!wrap_mode_q[2]) begin
						held_q <= lo;
					end else if (wrap_mode_q[3]) begin
						held_q <= hi;
					end
				end else begin
					held_q <= sum_q[VALUE_WIDTH-1:0];
				end
			end
			if (ctl.mod_fin) begin
				held_q <= below_q ? (hi - rem_q) : (lo + rem_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.tick_go   = tick_go;
	assign sts.mod_start = (over && wrap_mode_q[0] && !wrap_mode_q[1])
		|| (!over && under && wrap_mode_q[2] && !wrap_mode_q[3]);
	assign sts.mod_last  = (bit_cnt_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign current_value  = out_value_q;
	assign pending_change = out_pending_q;
	assign value_moved    = out_moved_q;

endmodule

// ----- rtl/rotary_encoder_range_counter_unit.sv -----
// Top level of the rotary encoder range counter: controller, datapath and checks.
// Usage:
// The input channel (in_valid/in_ready) carries one item per transfer: a command
// with the two raw contact levels and a value to load. Every item yields exactly
// one result on the output channel (out_valid/out_ready): the held value, the
// pending-change flag and whether this tick moved the value.
// The block works on one item at a time. A contact sample, set or read, or a tick
// that applies nothing, goes from its execute step straight to the result step, and the next
// transfer can be taken in the cycle its result is first offered. A tick that
// applies steps also passes a multiply, an add and a range check, and when it wraps
// the excess around a bound it runs through a one-bit-per-cycle remainder unit
// against the range span.
// The result sits in an output register, so the receiver may stall freely; the
// block waits in its final step until that register is free, then takes the next
// transfer. Configuration registers are written through cfg_write_en, cfg_index
// and cfg_data and take effect at once; the held value is not re-clamped.
// Reset restores the range 10 to 20, step size one, clip at both ends, high
// level as closed, ticks enabled, and clears the decoder, step count and flag
// with the held value at 10.
module rotary_encoder_range_counter_unit #(
	parameter int VALUE_WIDTH = rerc_pkg::RERC_VALUE_WIDTH,
	parameter int MAX_STEPS   = rerc_pkg::RERC_MAX_STEPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rerc_pkg::REG_IDX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]             cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rerc_pkg::CMD_WIDTH-1:0]     command,
	input  logic                               clock_contact,
	input  logic                               direction_contact,
	input  logic signed [VALUE_WIDTH-1:0]      new_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [VALUE_WIDTH-1:0]      current_value,
	output logic                               pending_change,
	output logic                               value_moved
);
	import rerc_pkg::*;

	rerc_ctl_t ctl;
	rerc_sts_t sts;

	rerc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	rerc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_STEPS   (MAX_STEPS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.command           (command),
		.clock_contact     (clock_contact),
		.direction_contact (direction_contact),
		.new_value         (new_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.current_value     (current_value),
		.pending_change    (pending_change),
		.value_moved       (value_moved),
		.ctl               (ctl),
		.sts               (sts)
	);

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A second transfer was taken while an item was in progress.");

	a_moved_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_moved |-> pending_change)
		else $error("A tick moved the value without raising the pending flag.");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.cap, ctl.exec, ctl.add, ctl.chk, ctl.mod_step, ctl.mod_fin,
			ctl.load_out}))
		else $error("The controller issued more than one datapath command.");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !out_valid || out_ready)
		else $error("A result was loaded over one that was not yet taken.");

endmodule
